/* rtl/core/tss_pkg.sv */
// Shared constants, codes and helper functions for the track selection unit.
package tss_pkg;

    localparam int unsigned TRACK_W          = 16;
    localparam int unsigned KIND_W           = 4;
    localparam int unsigned PIDX_IN_W        = 3;
    localparam int unsigned CFG_IDX_W        = 3;
    localparam int unsigned CFG_DATA_W       = 16;
    localparam int unsigned PRESET_COUNT_DEF = 6;
    localparam int unsigned RETRY_LIMIT_DEF  = 16;

    localparam logic [TRACK_W-1:0] NO_TRACK   = 16'hFFFF;
    localparam logic [TRACK_W-1:0] SPAN_EXTRA = 16'd500;

    localparam logic [KIND_W-1:0] KIND_FWD      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_BACK     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_NOSIGN   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_FOLDER   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_PRESET   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SHUFFLE  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_OPENED   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SHUTDOWN = 4'd7;
    localparam logic [KIND_W-1:0] KIND_RESEED   = 4'd8;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SEED  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    function automatic logic [TRACK_W-1:0] seed_advance(input logic [TRACK_W-1:0] s);
        logic [TRACK_W-1:0] x;
        x = s;
        x = x ^ (x << 7);
        x = x ^ (x >> 9);
        x = x ^ (x << 8);
        return x;
    endfunction

    function automatic logic [TRACK_W-1:0] skip_wrap(input logic [TRACK_W-1:0] t);
        return (t == NO_TRACK) ? '0 : t;
    endfunction

endpackage

/* rtl/core/tss_in_if.sv */
// Event channel: valid/ready handshake with the event word.
interface tss_in_if;
    import tss_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [TRACK_W-1:0]     folder_first;
    logic [TRACK_W-1:0]     folder_last;
    logic [PIDX_IN_W-1:0]   preset_index;
    logic [TRACK_W-1:0]     value;

    modport source (output valid, kind, folder_first, folder_last, preset_index, value,
                    input ready);
    modport sink   (input valid, kind, folder_first, folder_last, preset_index, value,
                    output ready);
endinterface

/* rtl/core/tss_out_if.sv */
// Result channel: valid/ready handshake with the result word.
interface tss_out_if;
    import tss_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [TRACK_W-1:0]     next_track;
    logic                   stop_playback;
    logic                   shuffle_on;
    logic [TRACK_W-1:0]     current_track;

    modport source (output valid, next_track, stop_playback, shuffle_on, current_track,
                    input ready);
    modport sink   (input valid, next_track, stop_playback, shuffle_on, current_track,
                    output ready);
endinterface

/* rtl/core/tss_mod_unit.sv */
// Bit-serial restoring modulo unit: one quotient bit per cycle.
module tss_mod_unit
    import tss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TRACK_W-1:0] i_dividend,
    input  logic [TRACK_W-1:0] i_divisor,
    output logic               o_done,
    output logic [TRACK_W-1:0] o_rem
);

    localparam int unsigned CNT_W = $clog2(TRACK_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [TRACK_W-1:0] r_dvd, n_dvd;
    logic [TRACK_W-1:0] r_dsr, n_dsr;
    logic [TRACK_W-1:0] r_rem, n_rem;
    logic [TRACK_W:0]   trial;

    assign trial = {r_rem, r_dvd[TRACK_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = r_dvd << 1;
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = TRACK_W'(trial - {1'b0, r_dsr});
            end else begin
                n_rem = trial[TRACK_W-1:0];
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(TRACK_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* rtl/core/track_select_shuffle.sv */
// Track selection unit: skip, folder, preset and shuffle event handling.
// One event word is taken at a time. Events other than a shuffled forward skip with
// nothing pending go from accept straight to the done state. A shuffled forward skip
// draws a track with a bit-serial modulo unit: each draw is a seed step, a pass through
// the modulo unit and a compare (a zero span skips the modulo unit), and a draw is
// repeated while it hits the playing track, up to RETRY_LIMIT extra draws. The result
// sits in an output register, so the next event is taken while a result still waits
// on the sink.
module track_select_shuffle
    import tss_pkg::*;
#(
    parameter int unsigned PRESET_COUNT = PRESET_COUNT_DEF,
    parameter int unsigned RETRY_LIMIT  = RETRY_LIMIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tss_in_if.sink                i_evt,
    tss_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned PIDX_W = (PRESET_COUNT > 1) ? $clog2(PRESET_COUNT) : 1;
    localparam int unsigned TRY_W  = $clog2(RETRY_LIMIT + 1);

    t_state             r_state, n_state;
    logic [TRACK_W-1:0] r_seed, n_seed;
    logic [TRACK_W-1:0] r_play, n_play;
    logic [TRACK_W-1:0] r_pend, n_pend;
    logic               r_shuf, n_shuf;
    logic               r_stop, n_stop;
    logic [TRACK_W-1:0] r_first, n_first;
    logic [TRACK_W-1:0] r_span, n_span;
    logic [TRACK_W-1:0] r_pick, n_pick;
    logic [TRY_W-1:0]   r_tries, n_tries;
    logic               r_oval, n_oval;
    logic [TRACK_W-1:0] r_o_next, n_o_next;
    logic               r_o_stop, n_o_stop;
    logic               r_o_shuf, n_o_shuf;
    logic [TRACK_W-1:0] r_o_cur, n_o_cur;
    logic [TRACK_W-1:0] r_preset [PRESET_COUNT];

    logic               accept;
    logic [TRACK_W-1:0] top;
    logic [TRACK_W-1:0] span_in;
    logic [TRACK_W-1:0] base;
    logic [TRACK_W-1:0] step_trk;
    logic [TRACK_W-1:0] seed_next;
    logic               div_start;
    logic               div_done;
    logic [TRACK_W-1:0] div_rem;
    logic               pidx_ok;
    logic               cfg_ok;

    assign i_evt.ready = (r_state == ST_IDLE);
    assign accept      = i_evt.valid && i_evt.ready;

    assign top       = i_evt.folder_last + SPAN_EXTRA;
    assign span_in   = (top >= i_evt.folder_first) ? (top - i_evt.folder_first)
                                                   : (i_evt.folder_first - top);
    assign base      = (r_pend == NO_TRACK) ? r_play : r_pend;
    assign seed_next = seed_advance(r_seed);
    assign pidx_ok   = {1'b0, i_evt.preset_index} < (PIDX_IN_W + 1)'(PRESET_COUNT);
    assign cfg_ok    = {1'b0, i_cfg_idx} < (CFG_IDX_W + 1)'(PRESET_COUNT);

    always_comb begin
        case (i_evt.kind)
            KIND_FWD:  step_trk = base + 1'b1;
            KIND_BACK: step_trk = base - 1'b1;
            default:   step_trk = base;
        endcase
    end

    tss_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (seed_next),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state   = r_state;
        n_seed    = r_seed;
        n_play    = r_play;
        n_pend    = r_pend;
        n_shuf    = r_shuf;
        n_stop    = r_stop;
        n_first   = r_first;
        n_span    = r_span;
        n_pick    = r_pick;
        n_tries   = r_tries;
        n_oval    = r_oval;
        n_o_next  = r_o_next;
        n_o_stop  = r_o_stop;
        n_o_shuf  = r_o_shuf;
        n_o_cur   = r_o_cur;
        div_start = 1'b0;

        if (r_oval && o_res.ready) begin
            n_oval = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DONE;
                    n_stop  = 1'b0;
                    case (i_evt.kind)
                        KIND_FWD, KIND_BACK, KIND_NOSIGN: begin
                            n_stop = 1'b1;
                            if (r_shuf) begin
                                if (i_evt.kind == KIND_FWD) begin
                                    if (r_pend == NO_TRACK) begin
                                        n_first = i_evt.folder_first;
                                        n_span  = span_in;
                                        n_tries = '0;
                                        n_state = ST_SEED;
                                    end
                                end else begin
                                    n_pend = skip_wrap(r_play);
                                end
                            end else begin
                                n_pend = skip_wrap(step_trk);
                            end
                        end
                        KIND_FOLDER: begin
                            if (r_pend == NO_TRACK) begin
                                n_pend = i_evt.folder_last;
                                n_stop = 1'b1;
                            end
                        end
                        KIND_PRESET: begin
                            if (pidx_ok && (r_pend == NO_TRACK)) begin
                                n_pend = r_preset[i_evt.preset_index[PIDX_W-1:0]];
                                n_stop = 1'b1;
                            end
                        end
                        KIND_SHUFFLE: begin
                            n_shuf = !r_shuf;
                        end
                        KIND_OPENED: begin
                            n_play = i_evt.value;
                            n_pend = NO_TRACK;
                        end
                        KIND_SHUTDOWN: begin
                            n_pend = r_play;
                        end
                        KIND_RESEED: begin
                            n_seed = (i_evt.value == '0) ? TRACK_W'(1) : i_evt.value;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEED: begin
                n_seed = seed_next;
                if (r_span == '0) begin
                    n_pick  = r_first;
                    n_state = ST_CHECK;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_pick  = div_rem + r_first;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if ((r_pick == r_play) && (r_tries < TRY_W'(RETRY_LIMIT))) begin
                    n_tries = r_tries + 1'b1;
                    n_state = ST_SEED;
                end else begin
                    n_pend  = skip_wrap(r_pick);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_oval || o_res.ready) begin
                    n_oval   = 1'b1;
                    n_o_next = r_pend;
                    n_o_stop = r_stop;
                    n_o_shuf = r_shuf;
                    n_o_cur  = r_play;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seed  <= TRACK_W'(1);
            r_play  <= NO_TRACK;
            r_pend  <= NO_TRACK;
            r_shuf  <= 1'b0;
            r_stop  <= 1'b0;
            r_tries <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seed  <= n_seed;
            r_play  <= n_play;
            r_pend  <= n_pend;
            r_shuf  <= n_shuf;
            r_stop  <= n_stop;
            r_tries <= n_tries;
            r_oval  <= n_oval;
        end
        r_first  <= n_first;
        r_span   <= n_span;
        r_pick   <= n_pick;
        r_o_next <= n_o_next;
        r_o_stop <= n_o_stop;
        r_o_shuf <= n_o_shuf;
        r_o_cur  <= n_o_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PRESET_COUNT; i++) begin
                r_preset[i] <= '0;
            end
        end else if (i_cfg_we && cfg_ok) begin
            r_preset[i_cfg_idx[PIDX_W-1:0]] <= i_cfg_data[TRACK_W-1:0];
        end
    end

    assign o_res.valid         = r_oval;
    assign o_res.next_track    = r_o_next;
    assign o_res.stop_playback = r_o_stop;
    assign o_res.shuffle_on    = r_o_shuf;
    assign o_res.current_track = r_o_cur;

endmodule

/* rtl/core/tss_checker.sv */
// Port-level checker for the track selection unit, bound to the top level.
module tss_checker
    import tss_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [TRACK_W-1:0] i_out_next,
    input logic [TRACK_W-1:0] i_out_cur
);

    a_out_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("event taken while previous event still in work");

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_next) && $stable(i_out_cur)))
        else $error("result word changed while stalled");

endmodule

bind track_select_shuffle tss_checker u_tss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_evt.valid),
    .i_in_ready  (i_evt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_next  (o_res.next_track),
    .i_out_cur   (o_res.current_track)
);

/* tb/testbench.sv */
// Self-checking testbench for track_select_shuffle: scoreboard class, paced traffic.
module testbench;
    import tss_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned RANDOM_WORDS = 1700;
    localparam int unsigned PHASES       = 4;
    localparam int unsigned TAIL_CYCLES  = 20;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [TRACK_W-1:0]   first;
        logic [TRACK_W-1:0]   last;
        logic [PIDX_IN_W-1:0] pidx;
        logic [TRACK_W-1:0]   value;
    } event_word_t;

    typedef struct packed {
        logic [TRACK_W-1:0] next_track;
        logic               stop_playback;
        logic               shuffle_on;
        logic [TRACK_W-1:0] current_track;
    } result_word_t;

    class track_ledger;
        localparam int unsigned PRINT_CAP = 200;

        logic [TRACK_W-1:0] presets [PRESET_COUNT_DEF];
        logic [TRACK_W-1:0] seed;
        logic [TRACK_W-1:0] playing;
        logic [TRACK_W-1:0] pending;
        logic               shuffle;
        result_word_t       expected_results [$];
        int unsigned        errors;
        int unsigned        results_checked;
        int unsigned        draws;
        int unsigned        retried_skips;

        function new();
            foreach (presets[i]) presets[i] = '0;
            seed            = 16'd1;
            playing         = NO_TRACK;
            pending         = NO_TRACK;
            shuffle         = 1'b0;
            errors          = 0;
            results_checked = 0;
            draws           = 0;
            retried_skips   = 0;
        endfunction

        function void set_preset(int unsigned idx, logic [TRACK_W-1:0] data);
            if (idx < PRESET_COUNT_DEF) presets[idx] = data;
        endfunction

        function logic [TRACK_W-1:0] step_seed(logic [TRACK_W-1:0] s);
            logic [TRACK_W-1:0] x;
            x = s;
            x = x ^ (x << 7);
            x = x ^ (x >> 9);
            x = x ^ (x << 8);
            return x;
        endfunction

        function logic [TRACK_W-1:0] draw_pick(logic [TRACK_W-1:0] first,
                                               logic [TRACK_W-1:0] last);
            logic [TRACK_W-1:0] top;
            logic [TRACK_W-1:0] span;
            top  = last + SPAN_EXTRA;
            span = (top >= first) ? top - first : first - top;
            seed = step_seed(seed);
            draws++;
            if (span == '0) return first;
            return first + seed % span;
        endfunction

        function void note_event(event_word_t w);
            result_word_t       r;
            logic               stop;
            logic [TRACK_W-1:0] pick;
            int unsigned        tries;
            stop = 1'b0;
            case (w.kind)
                KIND_FWD, KIND_BACK, KIND_NOSIGN: begin
                    stop = 1'b1;
                    if (shuffle) begin
                        if (w.kind == KIND_FWD) begin
                            if (pending == NO_TRACK) begin
                                tries = 0;
                                pick  = draw_pick(w.first, w.last);
                                while (pick == playing && tries < RETRY_LIMIT_DEF) begin
                                    pick = draw_pick(w.first, w.last);
                                    tries++;
                                end
                                if (tries != 0) retried_skips++;
                                pending = pick;
                            end
                        end else begin
                            pending = playing;
                        end
                    end else begin
                        if (pending == NO_TRACK) pending = playing;
                        if (w.kind == KIND_FWD) pending = pending + 1'b1;
                        else if (w.kind == KIND_BACK) pending = pending - 1'b1;
                    end
                    if (pending == NO_TRACK) pending = '0;
                end
                KIND_FOLDER: begin
                    if (pending == NO_TRACK) begin
                        pending = w.last;
                        stop    = 1'b1;
                    end
                end
                KIND_PRESET: begin
                    if (w.pidx < PRESET_COUNT_DEF && pending == NO_TRACK) begin
                        pending = presets[w.pidx];
                        stop    = 1'b1;
                    end
                end
                KIND_SHUFFLE:  shuffle = !shuffle;
                KIND_OPENED: begin
                    playing = w.value;
                    pending = NO_TRACK;
                end
                KIND_SHUTDOWN: pending = playing;
                KIND_RESEED:   seed = (w.value == '0) ? 16'd1 : w.value;
                default: ;
            endcase
            r.next_track    = pending;
            r.stop_playback = stop;
            r.shuffle_on    = shuffle;
            r.current_track = playing;
            expected_results.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_CAP) $display("ERROR: %s", what);
        endtask

        task check_result(result_word_t got);
            result_word_t want;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected word: next %0d cur %0d",
                                 got.next_track, got.current_track));
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (got.next_track !== want.next_track)
                report($sformatf("word %0d next_track %0d, want %0d",
                                 results_checked, got.next_track, want.next_track));
            if (got.stop_playback !== want.stop_playback)
                report($sformatf("word %0d stop_playback %0b, want %0b",
                                 results_checked, got.stop_playback, want.stop_playback));
            if (got.shuffle_on !== want.shuffle_on)
                report($sformatf("word %0d shuffle_on %0b, want %0b",
                                 results_checked, got.shuffle_on, want.shuffle_on));
            if (got.current_track !== want.current_track)
                report($sformatf("word %0d current_track %0d, want %0d",
                                 results_checked, got.current_track, want.current_track));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tss_in_if  evt_bus ();
    tss_out_if res_bus ();

    track_ledger        ledger;
    bit                 sender_burst;
    bit                 sink_burst;
    int unsigned        cycle_count;
    int unsigned        words_sent;
    logic [TRACK_W-1:0] cur_first;
    logic [TRACK_W-1:0] cur_last;

    track_select_shuffle #(
        .PRESET_COUNT (PRESET_COUNT_DEF),
        .RETRY_LIMIT  (RETRY_LIMIT_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_bus),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [TRACK_W-1:0] first,
                             input logic [TRACK_W-1:0] last,
                             input logic [PIDX_IN_W-1:0] pidx,
                             input logic [TRACK_W-1:0] value);
        event_word_t w;
        int unsigned gap;
        w   = '{kind, first, last, pidx, value};
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            evt_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_bus.valid        <= 1'b1;
        evt_bus.kind         <= kind;
        evt_bus.folder_first <= first;
        evt_bus.folder_last  <= last;
        evt_bus.preset_index <= pidx;
        evt_bus.value        <= value;
        @(posedge i_clk);
        while (!evt_bus.ready) @(posedge i_clk);
        ledger.note_event(w);
        words_sent++;
    endtask

    task automatic drain_results();
        evt_bus.valid <= 1'b0;
        while (ledger.expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_presets(input logic [TRACK_W-1:0] vals [PRESET_COUNT_DEF]);
        logic [CFG_DATA_W-1:0] junk;
        for (int unsigned i = 0; i < (1 << CFG_IDX_W); i++) begin
            junk     = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= (i < PRESET_COUNT_DEF) ? vals[i] : junk;
            @(posedge i_clk);
            ledger.set_preset(i, (i < PRESET_COUNT_DEF) ? vals[i] : junk);
        end
        cfg_we <= 1'b0;
    endtask

    // result side: random stall per word, sample at the edge
    initial begin
        int unsigned  stall;
        result_word_t got;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_bus.valid) @(posedge i_clk);
            got.next_track    = res_bus.next_track;
            got.stop_playback = res_bus.stop_playback;
            got.shuffle_on    = res_bus.shuffle_on;
            got.current_track = res_bus.current_track;
            ledger.check_result(got);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ERROR: timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [TRACK_W-1:0]   preset_vals [PRESET_COUNT_DEF];
        logic [KIND_W-1:0]    k;
        logic [TRACK_W-1:0]   f;
        logic [TRACK_W-1:0]   l;
        logic [TRACK_W-1:0]   v;
        logic [PIDX_IN_W-1:0] p;
        int unsigned          r;
        int unsigned          counted;
        ledger               = new();
        words_sent           = 0;
        counted              = 0;
        cur_first            = 16'd100;
        cur_last             = 16'd200;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        evt_bus.valid        <= 1'b0;
        evt_bus.kind         <= '0;
        evt_bus.folder_first <= '0;
        evt_bus.folder_last  <= '0;
        evt_bus.preset_index <= '0;
        evt_bus.value        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        preset_vals = '{16'h0000, 16'hFFFF, 16'h1234, 16'hA5A5, 16'h8000, 16'h7FFF};
        program_presets(preset_vals);

        // shuffle off: increment from no track, decrement wrap, no-sign skip
        send_word(KIND_FWD,      16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF);
        send_word(KIND_BACK,     16'h0000, 16'h0000, 3'd0, 16'h0000);
        send_word(KIND_NOSIGN,   16'hFFFF, 16'h0000, 3'd5, 16'hFFFF);
        send_word(KIND_FOLDER,   16'h0000, 16'h1111, 3'd0, 16'h0000);
        send_word(KIND_OPENED,   16'h0000, 16'h0000, 3'd0, 16'hFFFF);
        send_word(KIND_FOLDER,   16'h0000, 16'hFFFF, 3'd0, 16'h0000);
        send_word(KIND_PRESET,   16'h0000, 16'h0000, 3'd1, 16'h0000);
        send_word(KIND_PRESET,   16'h0000, 16'h0000, 3'd7, 16'h0000);
        send_word(KIND_PRESET,   16'h0000, 16'h0000, 3'd6, 16'h0000);
        send_word(KIND_OPENED,   16'h0000, 16'h0000, 3'd0, 16'h0000);
        send_word(KIND_PRESET,   16'h0000, 16'h0000, 3'd0, 16'h0000);
        send_word(KIND_SHUTDOWN, 16'h0000, 16'h0000, 3'd0, 16'h0000);
        send_word(KIND_RESEED,   16'h0000, 16'h0000, 3'd0, 16'h0000);
        // shuffle on: span of one forces every retry, span zero, reversed span
        send_word(KIND_SHUFFLE,  16'h0000, 16'h0000, 3'd0, 16'h0000);
        send_word(KIND_OPENED,   16'h0000, 16'h0000, 3'd0, 16'd10);
        send_word(KIND_FWD,      16'd10,   16'd65047, 3'd0, 16'h0000);
        send_word(KIND_OPENED,   16'h0000, 16'h0000, 3'd0, 16'd10);
        send_word(KIND_FWD,      16'd10,   16'd65046, 3'd0, 16'h0000);
        send_word(KIND_OPENED,   16'h0000, 16'h0000, 3'd0, 16'd5);
        send_word(KIND_FWD,      16'hFFFF, 16'd65035, 3'd0, 16'h0000);
        send_word(KIND_OPENED,   16'h0000, 16'h0000, 3'd0, 16'd300);
        send_word(KIND_FWD,      16'd1000, 16'h0000, 3'd0, 16'h0000);
        send_word(KIND_FWD,      16'd1000, 16'h0000, 3'd0, 16'h0000);
        send_word(KIND_BACK,     16'h0000, 16'h0000, 3'd0, 16'h0000);
        send_word(KIND_NOSIGN,   16'h0000, 16'h0000, 3'd0, 16'h0000);
        send_word(KIND_RESEED,   16'h0000, 16'h0000, 3'd0, 16'hFFFF);
        send_word({KIND_W{1'b1}}, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF);
        send_word(KIND_RESEED + 1'b1, 16'h0000, 16'h0000, 3'd0, 16'h0000);
        send_word(KIND_SHUFFLE,  16'h0000, 16'h0000, 3'd0, 16'h0000);

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            drain_results();
            foreach (preset_vals[i]) begin
                case (phase)
                    1:       preset_vals[i] = 16'h0000;
                    2:       preset_vals[i] = 16'hFFFF;
                    default: preset_vals[i] = TRACK_W'($urandom_range(0, 16'hFFFF));
                endcase
            end
            program_presets(preset_vals);
            while (counted < RANDOM_WORDS / PHASES * (phase + 1)) begin
                if ($urandom_range(0, 63) == 0) begin
                    sender_burst = ($urandom_range(0, 3) == 0);
                    sink_burst   = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 99) == 0) drain_results();
                if ($urandom_range(0, 39) == 0) begin
                    cur_first = ($urandom_range(0, 3) == 0)
                                ? TRACK_W'($urandom_range(0, 16'hFFFF))
                                : TRACK_W'($urandom_range(0, 2000));
                    case ($urandom_range(0, 4))
                        0: cur_last = cur_first - SPAN_EXTRA + TRACK_W'($urandom_range(0, 3));
                        1: cur_last = cur_first - SPAN_EXTRA + TRACK_W'($urandom_range(0, 64));
                        2: cur_last = cur_first - SPAN_EXTRA - TRACK_W'($urandom_range(0, 64));
                        3: cur_last = TRACK_W'($urandom_range(0, 16'hFFFF));
                        default: cur_last = NO_TRACK;
                    endcase
                end
                f = ($urandom_range(0, 7) == 0) ? TRACK_W'($urandom_range(0, 16'hFFFF))
                                                : cur_first;
                l = ($urandom_range(0, 7) == 0) ? TRACK_W'($urandom_range(0, 16'hFFFF))
                                                : cur_last;
                p = PIDX_IN_W'($urandom_range(0, 7));
                v = TRACK_W'($urandom_range(0, 16'hFFFF));
                r = $urandom_range(0, 99);
                if (r < 28)      k = KIND_FWD;
                else if (r < 34) k = KIND_BACK;
                else if (r < 40) k = KIND_NOSIGN;
                else if (r < 47) k = KIND_FOLDER;
                else if (r < 55) k = KIND_PRESET;
                else if (r < 62) k = KIND_SHUFFLE;
                else if (r < 80) k = KIND_OPENED;
                else if (r < 85) k = KIND_SHUTDOWN;
                else if (r < 92) k = KIND_RESEED;
                else             k = KIND_W'($urandom_range(KIND_RESEED + 1, {KIND_W{1'b1}}));
                if (k == KIND_OPENED && $urandom_range(0, 3) != 0)
                    v = cur_first + TRACK_W'($urandom_range(0, 3));
                if (k == KIND_RESEED && $urandom_range(0, 9) == 0)
                    v = '0;
                send_word(k, f, l, p, v);
                counted++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.expected_results.size() != 0)
            ledger.report($sformatf("%0d words never arrived",
                                    ledger.expected_results.size()));
        $display("Run: %0d event words sent, %0d result words checked, %0d cycles",
                 words_sent, ledger.results_checked, cycle_count);
        $display("Shuffle: %0d seed draws, %0d forward skips that had to redraw",
                 ledger.draws, ledger.retried_skips);
        if (ledger.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/tss_pkg.sv
rtl/core/tss_in_if.sv
rtl/core/tss_out_if.sv
rtl/core/tss_mod_unit.sv
rtl/core/track_select_shuffle.sv
rtl/core/tss_checker.sv
tb/testbench.sv
